// ===== design/blc_pkg.sv =====
package blc_pkg;

    localparam int ENTRIES  = 16;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int AGE_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int KEY_W    = 48;
    localparam int PAY_W    = 32;
    localparam int SIZE_W   = 24;
    localparam int CAP_W    = 28;
    localparam int EVO_W    = 5;
    localparam int ENT_W    = KEY_W + SIZE_W + PAY_W;
    localparam int TOTAL_W  = SIZE_W + $clog2(ENTRIES + 1);
    localparam int EXT_W    = (TOTAL_W > CAP_W) ? TOTAL_W : CAP_W;
    localparam int EVX_W    = (CNT_W > EVO_W) ? CNT_W : EVO_W;

    localparam logic [1:0] KIND_GET   = 2'd0;
    localparam logic [1:0] KIND_PUT   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [2:0] RANK_NOP     = 3'd0;
    localparam logic [2:0] RANK_PROMOTE = 3'd1;
    localparam logic [2:0] RANK_REMOVE  = 3'd2;
    localparam logic [2:0] RANK_INSERT  = 3'd3;
    localparam logic [2:0] RANK_CLEAR   = 3'd4;

    typedef struct packed {
        logic [2:0]       op;
        logic [IDX_W-1:0] idx;
    } rank_cmd_t;

    typedef struct packed {
        logic [ENTRIES-1:0] valid;
        logic [IDX_W-1:0]   oldest;
        logic [CNT_W-1:0]   count;
    } rank_stat_t;

endpackage

// ===== design/byte_budget_lru_cache_core.sv =====
// Size-weighted LRU cache core.
// Requests enter on the in_valid/in_ready channel with kind, key, payload, byte_size
// and data_present; each request gives exactly one result beat on out_valid/out_ready.
// The byte budget is written on the cfg channel, which is always ready; zero means
// no byte limit. Write it only while no request is in flight.
// Keys, sizes and payloads live in one RAM with a registered read port, and the
// table is searched by streaming that RAM, one entry a cycle. A get scans, decides and
// registers its result beat. A put also inserts and checks the budget; a full table
// first has its oldest entry read and removed, and each budget eviction reads and
// removes the oldest entry and checks again. A clear, a rejected put or an unused kind
// skips the scan. Recency ranks and valid bits sit in flip-flops.
// A new request is accepted while a finished result still waits in the output
// register; when the receiver stalls, the next result waits until that beat goes.
// Reset empties the table, zeroes the byte total and the budget, and drops any
// pending result.
module byte_budget_lru_cache_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   kind,
    input  logic [blc_pkg::KEY_W-1:0]    key,
    input  logic [blc_pkg::PAY_W-1:0]    payload,
    input  logic [blc_pkg::SIZE_W-1:0]   byte_size,
    input  logic                         data_present,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic                         rejected,
    output logic [blc_pkg::PAY_W-1:0]    found_payload,
    output logic [blc_pkg::SIZE_W-1:0]   found_size,
    output logic [blc_pkg::EVO_W-1:0]    evicted_count,
    output logic [blc_pkg::CAP_W-1:0]    total_bytes,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [blc_pkg::CAP_W-1:0]    cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_FULLRD = 4'd3;
    localparam logic [3:0] S_FULLRM = 4'd4;
    localparam logic [3:0] S_INSERT = 4'd5;
    localparam logic [3:0] S_CHECK  = 4'd6;
    localparam logic [3:0] S_EVRD   = 4'd7;
    localparam logic [3:0] S_EVRM   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]                   state_reg, state_next;
    logic [blc_pkg::CAP_W-1:0]    cap_reg;
    logic [blc_pkg::TOTAL_W-1:0]  total_reg, total_next;
    logic [blc_pkg::CNT_W-1:0]    ev_reg, ev_next;
    logic                         out_valid_reg, out_valid_next;

    logic [blc_pkg::IDX_W-1:0]    issue_reg, issue_next;
    logic                         issue_done_reg, issue_done_next;
    logic                         pend_reg, pend_next;
    logic [blc_pkg::IDX_W-1:0]    pend_idx_reg;
    logic                         found_reg, found_next;
    logic                         free_found_reg, free_found_next;

    logic [1:0]                   kind_reg;
    logic [blc_pkg::KEY_W-1:0]    key_reg;
    logic [blc_pkg::PAY_W-1:0]    pay_reg;
    logic [blc_pkg::SIZE_W-1:0]   size_reg;
    logic                         present_reg;
    logic [blc_pkg::IDX_W-1:0]    match_idx_reg;
    logic [blc_pkg::SIZE_W-1:0]   match_size_reg;
    logic [blc_pkg::PAY_W-1:0]    match_pay_reg;
    logic [blc_pkg::IDX_W-1:0]    free_idx_reg;
    logic [blc_pkg::IDX_W-1:0]    slot_reg, slot_next;
    logic [blc_pkg::IDX_W-1:0]    victim_reg, victim_next;
    logic                         load_out;

    logic                         o_hit_reg, o_rej_reg;
    logic [blc_pkg::PAY_W-1:0]    o_pay_reg;
    logic [blc_pkg::SIZE_W-1:0]   o_size_reg;
    logic [blc_pkg::EVO_W-1:0]    o_ev_reg;
    logic [blc_pkg::CAP_W-1:0]    o_total_reg;

    blc_pkg::rank_cmd_t           rank_cmd;
    blc_pkg::rank_stat_t          rank_stat;

    logic                         ram_we;
    logic [blc_pkg::IDX_W-1:0]    ram_raddr;
    logic [blc_pkg::ENT_W-1:0]    ram_wdata, ram_rdata;
    logic [blc_pkg::KEY_W-1:0]    rd_key;
    logic [blc_pkg::SIZE_W-1:0]   rd_size;
    logic [blc_pkg::PAY_W-1:0]    rd_pay;

    logic                         in_fire;
    logic                         is_reject;
    logic                         key_match;
    logic [blc_pkg::EXT_W-1:0]    total_ext;
    logic [blc_pkg::EVX_W-1:0]    ev_ext;
    logic                         over_budget;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign rd_key  = ram_rdata[blc_pkg::ENT_W-1 -: blc_pkg::KEY_W];
    assign rd_size = ram_rdata[blc_pkg::PAY_W +: blc_pkg::SIZE_W];
    assign rd_pay  = ram_rdata[blc_pkg::PAY_W-1:0];

    assign is_reject = (kind_reg == blc_pkg::KIND_PUT) && !present_reg && (size_reg != '0);
    assign key_match = pend_reg && rank_stat.valid[pend_idx_reg] && (rd_key == key_reg);

    assign total_ext   = blc_pkg::EXT_W'(total_reg);
    assign ev_ext      = blc_pkg::EVX_W'(ev_reg);
    assign over_budget = (cap_reg != '0) && (total_ext > blc_pkg::EXT_W'(cap_reg))
                         && (rank_stat.count != '0);

    assign ram_wdata = {key_reg, size_reg, present_reg ? pay_reg : blc_pkg::PAY_W'(0)};

    blc_ram #(
        .WIDTH (blc_pkg::ENT_W),
        .DEPTH (blc_pkg::ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    blc_rank u_rank (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (rank_cmd),
        .stat  (rank_stat)
    );

    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        ev_next         = ev_reg;
        issue_next      = issue_reg;
        issue_done_next = issue_done_reg;
        pend_next       = pend_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        slot_next       = slot_reg;
        victim_next     = victim_reg;
        rank_cmd.op     = blc_pkg::RANK_NOP;
        rank_cmd.idx    = match_idx_reg;
        ram_we          = 1'b0;
        ram_raddr       = issue_reg;
        load_out        = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ev_next         = '0;
                    issue_next      = '0;
                    issue_done_next = 1'b0;
                    pend_next       = 1'b0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_DECIDE;
                    if (kind == blc_pkg::KIND_GET || (kind == blc_pkg::KIND_PUT
                        && !(!data_present && byte_size != '0)))
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (!issue_done_reg)
                begin
                    issue_next = issue_reg + blc_pkg::IDX_W'(1);
                    if (issue_reg == blc_pkg::IDX_W'(blc_pkg::ENTRIES - 1))
                    begin
                        issue_done_next = 1'b1;
                    end
                end
                pend_next = !issue_done_reg;
                if (key_match && !found_reg)
                begin
                    found_next = 1'b1;
                end
                if (pend_reg && !rank_stat.valid[pend_idx_reg] && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                end
                if (issue_done_reg && pend_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                if (kind_reg == blc_pkg::KIND_GET)
                begin
                    if (found_reg)
                    begin
                        rank_cmd.op = blc_pkg::RANK_PROMOTE;
                    end
                end
                else if (kind_reg == blc_pkg::KIND_PUT && !is_reject)
                begin
                    if (found_reg)
                    begin
                        rank_cmd.op = blc_pkg::RANK_REMOVE;
                        total_next  = total_reg - blc_pkg::TOTAL_W'(match_size_reg);
                        slot_next   = match_idx_reg;
                        if (free_found_reg && free_idx_reg < match_idx_reg)
                        begin
                            slot_next = free_idx_reg;
                        end
                        state_next = S_INSERT;
                    end
                    else if (rank_stat.count == blc_pkg::CNT_W'(blc_pkg::ENTRIES))
                    begin
                        state_next = S_FULLRD;
                    end
                    else
                    begin
                        slot_next  = free_idx_reg;
                        state_next = S_INSERT;
                    end
                end
                else if (kind_reg == blc_pkg::KIND_CLEAR)
                begin
                    rank_cmd.op = blc_pkg::RANK_CLEAR;
                    total_next  = '0;
                end
            end
            S_FULLRD, S_EVRD:
            begin
                ram_raddr   = rank_stat.oldest;
                victim_next = rank_stat.oldest;
                state_next  = (state_reg == S_FULLRD) ? S_FULLRM : S_EVRM;
            end
            S_FULLRM, S_EVRM:
            begin
                rank_cmd.op  = blc_pkg::RANK_REMOVE;
                rank_cmd.idx = victim_reg;
                total_next   = total_reg - blc_pkg::TOTAL_W'(rd_size);
                ev_next      = ev_reg + blc_pkg::CNT_W'(1);
                slot_next    = victim_reg;
                state_next   = (state_reg == S_FULLRM) ? S_INSERT : S_CHECK;
            end
            S_INSERT:
            begin
                ram_we       = 1'b1;
                rank_cmd.op  = blc_pkg::RANK_INSERT;
                rank_cmd.idx = slot_reg;
                total_next   = total_reg + blc_pkg::TOTAL_W'(size_reg);
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = over_budget ? S_EVRD : S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cap_reg        <= '0;
            total_reg      <= '0;
            ev_reg         <= '0;
            out_valid_reg  <= 1'b0;
            issue_reg      <= '0;
            issue_done_reg <= 1'b0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            ev_reg         <= ev_next;
            out_valid_reg  <= out_valid_next;
            issue_reg      <= issue_next;
            issue_done_reg <= issue_done_next;
            pend_reg       <= pend_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        victim_reg   <= victim_next;
        pend_idx_reg <= issue_reg;
        if (in_fire)
        begin
            kind_reg    <= kind;
            key_reg     <= key;
            pay_reg     <= payload;
            size_reg    <= byte_size;
            present_reg <= data_present;
        end
        if (state_reg == S_SCAN && key_match && !found_reg)
        begin
            match_idx_reg  <= pend_idx_reg;
            match_size_reg <= rd_size;
            match_pay_reg  <= rd_pay;
        end
        if (state_reg == S_SCAN && pend_reg && !rank_stat.valid[pend_idx_reg]
            && !free_found_reg)
        begin
            free_idx_reg <= pend_idx_reg;
        end
        if (load_out)
        begin
            o_hit_reg  <= (kind_reg == blc_pkg::KIND_GET) && found_reg;
            o_rej_reg  <= is_reject;
            o_pay_reg  <= ((kind_reg == blc_pkg::KIND_GET) && found_reg) ? match_pay_reg : '0;
            o_size_reg <= ((kind_reg == blc_pkg::KIND_GET) && found_reg) ? match_size_reg : '0;
            o_ev_reg   <= (ev_ext > blc_pkg::EVX_W'({blc_pkg::EVO_W{1'b1}}))
                          ? {blc_pkg::EVO_W{1'b1}} : blc_pkg::EVO_W'(ev_reg);
            o_total_reg <= (total_ext > blc_pkg::EXT_W'({blc_pkg::CAP_W{1'b1}}))
                           ? {blc_pkg::CAP_W{1'b1}} : blc_pkg::CAP_W'(total_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = o_hit_reg;
    assign rejected      = o_rej_reg;
    assign found_payload = o_pay_reg;
    assign found_size    = o_size_reg;
    assign evicted_count = o_ev_reg;
    assign total_bytes   = o_total_reg;

endmodule

// ===== design/blc_ram.sv =====
module blc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/blc_rank.sv =====
module blc_rank (
    input  logic                clk,
    input  logic                rst_n,
    input  blc_pkg::rank_cmd_t  cmd,
    output blc_pkg::rank_stat_t stat
);

    logic [blc_pkg::AGE_W-1:0] age_reg [blc_pkg::ENTRIES];
    logic [blc_pkg::AGE_W-1:0] age_next [blc_pkg::ENTRIES];
    logic [blc_pkg::ENTRIES-1:0] valid_reg;
    logic [blc_pkg::ENTRIES-1:0] valid_next;
    logic [blc_pkg::CNT_W-1:0] count_reg;
    logic [blc_pkg::CNT_W-1:0] count_next;
    logic [blc_pkg::AGE_W-1:0] sel_age;
    logic [blc_pkg::AGE_W-1:0] last_age;
    logic [blc_pkg::IDX_W-1:0] oldest;

    assign sel_age  = age_reg[cmd.idx];
    assign last_age = blc_pkg::AGE_W'(count_reg - blc_pkg::CNT_W'(1));

    // Ages form a permutation of the valid entries, so exactly one entry holds the
    // last rank and its index is the OR of the matching indexes.
    always_comb
    begin
        oldest = '0;
        for (int j = 0; j < blc_pkg::ENTRIES; j++)
        begin
            if (valid_reg[j] && age_reg[j] == last_age)
            begin
                oldest = oldest | blc_pkg::IDX_W'(j);
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int j = 0; j < blc_pkg::ENTRIES; j++)
        begin
            age_next[j] = age_reg[j];
        end
        unique case (cmd.op)
            blc_pkg::RANK_PROMOTE:
            begin
                for (int j = 0; j < blc_pkg::ENTRIES; j++)
                begin
                    if (valid_reg[j] && blc_pkg::IDX_W'(j) != cmd.idx && age_reg[j] < sel_age)
                    begin
                        age_next[j] = age_reg[j] + blc_pkg::AGE_W'(1);
                    end
                end
                age_next[cmd.idx] = '0;
            end
            blc_pkg::RANK_REMOVE:
            begin
                for (int j = 0; j < blc_pkg::ENTRIES; j++)
                begin
                    if (valid_reg[j] && blc_pkg::IDX_W'(j) != cmd.idx && age_reg[j] > sel_age)
                    begin
                        age_next[j] = age_reg[j] - blc_pkg::AGE_W'(1);
                    end
                end
                age_next[cmd.idx]   = '0;
                valid_next[cmd.idx] = 1'b0;
                count_next          = count_reg - blc_pkg::CNT_W'(1);
            end
            blc_pkg::RANK_INSERT:
            begin
                for (int j = 0; j < blc_pkg::ENTRIES; j++)
                begin
                    if (valid_reg[j])
                    begin
                        age_next[j] = age_reg[j] + blc_pkg::AGE_W'(1);
                    end
                end
                age_next[cmd.idx]   = '0;
                valid_next[cmd.idx] = 1'b1;
                count_next          = count_reg + blc_pkg::CNT_W'(1);
            end
            blc_pkg::RANK_CLEAR:
            begin
                for (int j = 0; j < blc_pkg::ENTRIES; j++)
                begin
                    age_next[j] = '0;
                end
                valid_next = '0;
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < blc_pkg::ENTRIES; j++)
            begin
                age_reg[j] <= '0;
            end
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            for (int j = 0; j < blc_pkg::ENTRIES; j++)
            begin
                age_reg[j] <= age_next[j];
            end
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    assign stat.valid  = valid_reg;
    assign stat.oldest = oldest;
    assign stat.count  = count_reg;

endmodule

// ===== design/blc_checker.sv =====
module blc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       hit,
    input logic                       rejected,
    input logic [blc_pkg::PAY_W-1:0]  found_payload,
    input logic [blc_pkg::SIZE_W-1:0] found_size,
    input logic [blc_pkg::EVO_W-1:0]  evicted_count,
    input logic [blc_pkg::CAP_W-1:0]  total_bytes
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(total_bytes) && $stable(hit))
        else $error("result changed while stalled");

    a_hit_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !rejected && evicted_count == '0)
        else $error("hit result carries put status");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> evicted_count == '0 && found_size == '0)
        else $error("rejected put changed the table");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> found_payload == '0 && found_size == '0)
        else $error("miss returned found data");

endmodule

bind byte_budget_lru_cache_core blc_checker u_blc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .rejected      (rejected),
    .found_payload (found_payload),
    .found_size    (found_size),
    .evicted_count (evicted_count),
    .total_bytes   (total_bytes)
);

// ===== sim/byte_budget_lru_cache_core_tb.sv =====
module byte_budget_lru_cache_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  DRAIN_WAIT  = 4 * blc_pkg::ENTRIES + 40;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [1:0]                   kind;
    logic [blc_pkg::KEY_W-1:0]    key;
    logic [blc_pkg::PAY_W-1:0]    payload;
    logic [blc_pkg::SIZE_W-1:0]   byte_size;
    logic                         data_present;
    logic                         out_valid;
    logic                         out_ready;
    logic                         hit;
    logic                         rejected;
    logic [blc_pkg::PAY_W-1:0]    found_payload;
    logic [blc_pkg::SIZE_W-1:0]   found_size;
    logic [blc_pkg::EVO_W-1:0]    evicted_count;
    logic [blc_pkg::CAP_W-1:0]    total_bytes;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [blc_pkg::CAP_W-1:0]    cfg_data;

    typedef struct packed {
        logic                       hit;
        logic                       rejected;
        logic [blc_pkg::PAY_W-1:0]  found_payload;
        logic [blc_pkg::SIZE_W-1:0] found_size;
        logic [blc_pkg::EVO_W-1:0]  evicted_count;
        logic [blc_pkg::CAP_W-1:0]  total_bytes;
    } lookup_result_t;

    lookup_result_t pending_results[$];

    logic                       tbl_valid [blc_pkg::ENTRIES];
    logic [blc_pkg::KEY_W-1:0]  tbl_key [blc_pkg::ENTRIES];
    logic [blc_pkg::SIZE_W-1:0] tbl_size [blc_pkg::ENTRIES];
    logic [blc_pkg::PAY_W-1:0]  tbl_pay [blc_pkg::ENTRIES];
    int unsigned                tbl_rank [blc_pkg::ENTRIES];
    longint unsigned            tbl_total;
    logic [blc_pkg::CAP_W-1:0]  budget;

    int  error_count;
    int  result_count;
    int  item_count;
    int  hit_count;
    int  evict_count;
    int  cycle_count;
    bit  sender_idle_on;
    bit  receiver_idle_on;
    int  long_hold;

    byte_budget_lru_cache_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .key           (key),
        .payload       (payload),
        .byte_size     (byte_size),
        .data_present  (data_present),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .rejected      (rejected),
        .found_payload (found_payload),
        .found_size    (found_size),
        .evicted_count (evicted_count),
        .total_bytes   (total_bytes),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int find_slot(logic [blc_pkg::KEY_W-1:0] k);
        for (int i = 0; i < blc_pkg::ENTRIES; i++)
            if (tbl_valid[i] && tbl_key[i] == k) return i;
        return -1;
    endfunction

    function automatic int least_recent();
        int best;
        best = -1;
        for (int i = 0; i < blc_pkg::ENTRIES; i++)
            if (tbl_valid[i] && (best < 0 || tbl_rank[i] > tbl_rank[best])) best = i;
        return best;
    endfunction

    function automatic void drop_slot(int s);
        for (int j = 0; j < blc_pkg::ENTRIES; j++)
            if (tbl_valid[j] && j != s && tbl_rank[j] > tbl_rank[s]) tbl_rank[j]--;
        tbl_total -= tbl_size[s];
        tbl_valid[s] = 1'b0;
        tbl_rank[s] = 0;
    endfunction

    function automatic lookup_result_t cache_access(logic [1:0] op,
                                                    logic [blc_pkg::KEY_W-1:0] k,
                                                    logic [blc_pkg::PAY_W-1:0] p,
                                                    logic [blc_pkg::SIZE_W-1:0] sz,
                                                    logic present);
        lookup_result_t r;
        int s;
        int o;
        int n;
        int ev;
        r = '0;
        ev = 0;
        if (op == blc_pkg::KIND_GET)
        begin
            s = find_slot(k);
            if (s >= 0)
            begin
                r.hit = 1'b1;
                r.found_payload = tbl_pay[s];
                r.found_size = tbl_size[s];
                for (int j = 0; j < blc_pkg::ENTRIES; j++)
                    if (tbl_valid[j] && j != s && tbl_rank[j] < tbl_rank[s]) tbl_rank[j]++;
                tbl_rank[s] = 0;
            end
        end
        else if (op == blc_pkg::KIND_PUT)
        begin
            if (!present && sz != 0)
            begin
                r.rejected = 1'b1;
            end
            else
            begin
                s = find_slot(k);
                if (s >= 0) drop_slot(s);
                n = 0;
                for (int j = 0; j < blc_pkg::ENTRIES; j++) if (tbl_valid[j]) n++;
                if (n >= blc_pkg::ENTRIES)
                begin
                    o = least_recent();
                    if (o >= 0)
                    begin
                        drop_slot(o);
                        ev++;
                    end
                end
                s = -1;
                for (int j = 0; j < blc_pkg::ENTRIES; j++)
                    if (!tbl_valid[j] && s < 0) s = j;
                if (s >= 0)
                begin
                    for (int j = 0; j < blc_pkg::ENTRIES; j++) if (tbl_valid[j]) tbl_rank[j]++;
                    tbl_valid[s] = 1'b1;
                    tbl_key[s] = k;
                    tbl_size[s] = sz;
                    tbl_pay[s] = present ? p : '0;
                    tbl_rank[s] = 0;
                    tbl_total += sz;
                end
                while (budget != 0 && tbl_total > budget)
                begin
                    o = least_recent();
                    if (o < 0) break;
                    drop_slot(o);
                    ev++;
                end
            end
        end
        else if (op == blc_pkg::KIND_CLEAR)
        begin
            for (int j = 0; j < blc_pkg::ENTRIES; j++)
            begin
                tbl_valid[j] = 1'b0;
                tbl_rank[j] = 0;
            end
            tbl_total = 0;
        end
        r.evicted_count = (ev > 31) ? 5'd31 : ev[blc_pkg::EVO_W-1:0];
        r.total_bytes = (tbl_total > 64'hFFFFFFF) ? {blc_pkg::CAP_W{1'b1}}
                                                  : tbl_total[blc_pkg::CAP_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        error_count++;
        $display("result %0d: %s is 0x%0h, expected 0x%0h", result_count, field, got, want);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("result %0d arrived with nothing expected", result_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
                if (rejected !== want.rejected)
                    report_mismatch("rejected", rejected, want.rejected);
                if (found_payload !== want.found_payload)
                    report_mismatch("found_payload", found_payload, want.found_payload);
                if (found_size !== want.found_size)
                    report_mismatch("found_size", found_size, want.found_size);
                if (evicted_count !== want.evicted_count)
                    report_mismatch("evicted_count", evicted_count, want.evicted_count);
                if (total_bytes !== want.total_bytes)
                    report_mismatch("total_bytes", total_bytes, want.total_bytes);
                if (want.hit) hit_count++;
                evict_count += want.evicted_count;
            end
            result_count++;
        end
    end

    // The receiver stalls in random bursts, or for one long stretch on request.
    always @(negedge clk)
    begin
        if (long_hold > 0)
        begin
            out_ready <= 1'b0;
            long_hold <= long_hold - 1;
        end
        else if (receiver_idle_on && $urandom_range(0, 9) < 3)
        begin
            out_ready <= 1'b0;
            long_hold <= $urandom_range(0, 5);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_item(logic [1:0] op, logic [blc_pkg::KEY_W-1:0] k,
                             logic [blc_pkg::PAY_W-1:0] p,
                             logic [blc_pkg::SIZE_W-1:0] sz, logic present);
        int gap;
        if (sender_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        kind = op;
        key = k;
        payload = p;
        byte_size = sz;
        data_present = present;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(cache_access(op, k, p, sz, present));
        item_count++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic set_budget(logic [blc_pkg::CAP_W-1:0] value);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        budget = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [blc_pkg::KEY_W-1:0] pick_key(int pool);
        if (pool == 0) return blc_pkg::KEY_W'({$urandom, $urandom});
        return blc_pkg::KEY_W'($urandom_range(0, pool - 1)) ^ 48'hA5A5_0000_0000;
    endfunction

    task automatic test_directed();
        send_item(blc_pkg::KIND_GET, '0, '0, '0, 1'b0);
        send_item(blc_pkg::KIND_PUT, '0, '0, '0, 1'b0);
        send_item(blc_pkg::KIND_PUT, {blc_pkg::KEY_W{1'b1}}, {blc_pkg::PAY_W{1'b1}},
                  {blc_pkg::SIZE_W{1'b1}}, 1'b1);
        send_item(blc_pkg::KIND_GET, {blc_pkg::KEY_W{1'b1}}, '0, '0, 1'b0);
        send_item(blc_pkg::KIND_GET, '0, '0, '0, 1'b1);
        send_item(blc_pkg::KIND_PUT, 48'h1, 32'h1234, 24'h10, 1'b0);
        send_item(blc_pkg::KIND_PUT, {blc_pkg::KEY_W{1'b1}}, 32'hDEAD_BEEF, 24'h5, 1'b1);
        send_item(blc_pkg::KIND_GET, {blc_pkg::KEY_W{1'b1}}, '0, '0, 1'b0);
        send_item(KIND_UNUSED, 48'h5555_5555_5555, 32'hAAAA_AAAA, 24'h55_5555, 1'b1);
        send_item(blc_pkg::KIND_CLEAR, '0, '0, '0, 1'b0);
        send_item(blc_pkg::KIND_GET, {blc_pkg::KEY_W{1'b1}}, '0, '0, 1'b0);
        for (int i = 0; i < blc_pkg::ENTRIES + 2; i++)
            send_item(blc_pkg::KIND_PUT, blc_pkg::KEY_W'(i), 32'h100 + i,
                      blc_pkg::SIZE_W'(i + 1), 1'b1);
        send_item(blc_pkg::KIND_GET, 48'h0, '0, '0, 1'b0);
        send_item(blc_pkg::KIND_GET, 48'h5, '0, '0, 1'b0);
    endtask

    task automatic test_budget_eviction();
        set_budget(28'd100);
        for (int i = 0; i < 12; i++)
            send_item(blc_pkg::KIND_PUT, blc_pkg::KEY_W'(i), $urandom,
                      blc_pkg::SIZE_W'($urandom_range(1, 40)), 1'b1);
        send_item(blc_pkg::KIND_PUT, 48'h77, 32'h1, 24'd150, 1'b1);
        send_item(blc_pkg::KIND_GET, 48'h77, '0, '0, 1'b0);
        set_budget({blc_pkg::CAP_W{1'b1}});
        for (int i = 0; i < blc_pkg::ENTRIES + 4; i++)
            send_item(blc_pkg::KIND_PUT, blc_pkg::KEY_W'(i), $urandom,
                      {blc_pkg::SIZE_W{1'b1}}, 1'b1);
        set_budget(28'd1);
        send_item(blc_pkg::KIND_PUT, 48'h9, 32'h9, 24'd1, 1'b1);
        send_item(blc_pkg::KIND_PUT, 48'hA, 32'hA, 24'd2, 1'b1);
        set_budget('0);
    endtask

    task automatic random_phase(int count, int pool, int max_size);
        int r;
        logic [1:0] op;
        logic present;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            op = (r < 45) ? blc_pkg::KIND_GET : (r < 93) ? blc_pkg::KIND_PUT
               : (r < 97) ? blc_pkg::KIND_CLEAR : KIND_UNUSED;
            present = ($urandom_range(0, 9) != 0);
            send_item(op, pick_key(pool), $urandom,
                      ($urandom_range(0, 15) == 0) ? '0
                      : blc_pkg::SIZE_W'($urandom_range(1, max_size)),
                      present);
        end
    endtask

    task automatic test_random();
        random_phase(250, 24, 200);
        set_budget(28'd600);
        random_phase(250, 24, 200);
        set_budget(28'd1000);
        random_phase(150, 40, 300);
        set_budget({blc_pkg::CAP_W{1'b1}});
        random_phase(150, 0, 24'hFF_FFFF);
        set_budget(28'd350);
        random_phase(150, 20, 100);
    endtask

    task automatic test_backpressure();
        @(posedge clk);
        long_hold = 300;
        @(negedge clk);
        random_phase(40, 12, 100);
        wait_drained();
        random_phase(40, 12, 100);
    endtask

    task automatic test_no_idle();
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        set_budget('0);
        random_phase(150, 20, 500);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = blc_pkg::KIND_GET;
        key = '0;
        payload = '0;
        byte_size = '0;
        data_present = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        error_count = 0;
        result_count = 0;
        item_count = 0;
        hit_count = 0;
        evict_count = 0;
        cycle_count = 0;
        long_hold = 0;
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
        budget = '0;
        tbl_total = 0;
        for (int i = 0; i < blc_pkg::ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_size[i] = '0;
            tbl_pay[i] = '0;
            tbl_rank[i] = 0;
        end
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_budget_eviction();
        test_random();
        test_backpressure();
        test_no_idle();
        if (pending_results.size() != 0)
        begin
            error_count++;
            $display("%0d expected results never arrived", pending_results.size());
        end
        $display("Ran %0d requests and checked %0d results over several byte budgets;",
                 item_count, result_count);
        $display("%0d gets hit and %0d entries were evicted.", hit_count, evict_count);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
